// ===== hw/rtl/sm4_pkg.sv =====
// ----------------------------------------------------------------------------
// SM4 package
// Shared constants, types and round functions of the SM4 block cipher unit.
// ----------------------------------------------------------------------------
package sm4_pkg;

	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = 4;
	localparam int BLOCK_W    = WORD_W * NUM_WORDS;
	localparam int NUM_ROUNDS = 32;
	localparam int RND_IDX_W  = $clog2(NUM_ROUNDS);
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 2'd3;

	// Operation flag carried in tuser.
	localparam logic OP_DECRYPT = 1'b0;
	localparam logic OP_ENCRYPT = 1'b1;

	typedef logic [NUM_ROUNDS-1:0][WORD_W-1:0] rk_vec_t;

	// One block in flight: word 0 sits in the lowest bits.
	typedef struct packed {
		logic                              op;
		logic [NUM_WORDS-1:0][WORD_W-1:0] x;
	} stage_t;

	typedef enum logic [1:0] {
		KS_LOAD,
		KS_RUN,
		KS_READY
	} kexp_state_t;

	// System parameter FK, element 0 last (in the lowest bits).
	localparam logic [NUM_WORDS-1:0][WORD_W-1:0] FK = {
		32'hb27022dc, 32'h677d9197, 32'h56aa3350, 32'ha3b1bac6
	};

	localparam logic [7:0] SBOX [256] = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	// Byte-wise substitution of a word.
	function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] r;
		for (int b = 0; b < WORD_W / 8; b++) begin
			r[8*b +: 8] = SBOX[v[8*b +: 8]];
		end
		return r;
	endfunction

	// Linear mix used by the data rounds.
	function automatic logic [WORD_W-1:0] data_mix(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] b;
		b = tau(v);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	// Linear mix used by the key schedule.
	function automatic logic [WORD_W-1:0] key_mix(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] b;
		b = tau(v);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// Chain constant CK: byte j of word i (most significant first) is (4i+j)*7 mod 256.
	function automatic logic [WORD_W-1:0] ck_word(input logic [RND_IDX_W-1:0] idx);
		logic [WORD_W-1:0] c;
		logic [7:0]        base;
		c    = '0;
		base = {1'b0, idx, 2'b00};
		for (int j = 0; j < 4; j++) begin
			c = {c[WORD_W-9:0], 8'((base + 8'(j)) * 8'd7)};
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/sm4_round.sv =====
// ----------------------------------------------------------------------------
// SM4 round stage
// One cipher round followed by its pipeline register.
// ----------------------------------------------------------------------------
module sm4_round (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  sm4_pkg::stage_t         in_blk,
	input  logic [sm4_pkg::WORD_W-1:0] rk,
	output logic                    out_valid,
	output sm4_pkg::stage_t         out_blk
);
	import sm4_pkg::*;

	logic            valid_s1;
	stage_t          blk_s1;
	stage_t          blk_d;
	logic [WORD_W-1:0] nx;

	// The round shifts the words down and appends the new one on top.
	always_comb begin
		nx          = in_blk.x[0] ^ data_mix(in_blk.x[1] ^ in_blk.x[2] ^ in_blk.x[3] ^ rk);
		blk_d.op    = in_blk.op;
		blk_d.x[0]  = in_blk.x[1];
		blk_d.x[1]  = in_blk.x[2];
		blk_d.x[2]  = in_blk.x[3];
		blk_d.x[3]  = nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s1 <= blk_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_blk   = blk_s1;

endmodule

// ===== hw/rtl/sm4_key_exp.sv =====
// ----------------------------------------------------------------------------
// SM4 key expansion
// Key registers, round-key sequencer and the 32-word round-key store.
// ----------------------------------------------------------------------------
module sm4_key_exp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sm4_pkg::WORD_W-1:0]    cfg_wdata,
	output logic                          keys_ready,
	output sm4_pkg::rk_vec_t              rk
);
	import sm4_pkg::*;

	localparam logic [RND_IDX_W-1:0] LAST_RND = RND_IDX_W'(NUM_ROUNDS - 1);

	kexp_state_t                      state_q, state_d;
	logic [NUM_WORDS-1:0][WORD_W-1:0] key_q;
	logic [NUM_WORDS-1:0][WORD_W-1:0] k_q;
	logic [RND_IDX_W-1:0]             cnt_q;
	rk_vec_t                          rk_q;
	logic [WORD_W-1:0]                nk;

	assign nk = k_q[0] ^ key_mix(k_q[1] ^ k_q[2] ^ k_q[3] ^ ck_word(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Any key write restarts the expansion from the load step.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			KS_LOAD:  state_d = KS_RUN;
			KS_RUN:   if (cnt_q == LAST_RND) state_d = KS_READY;
			KS_READY: state_d = KS_READY;
			default:  state_d = KS_LOAD;
		endcase
		if (cfg_we) begin
			state_d = KS_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KEY_0: key_q[0] <= cfg_wdata;
				REG_KEY_1: key_q[1] <= cfg_wdata;
				REG_KEY_2: key_q[2] <= cfg_wdata;
				REG_KEY_3: key_q[3] <= cfg_wdata;
				default:   key_q    <= key_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == KS_LOAD) begin
			cnt_q <= '0;
		end else if (state_q == KS_RUN) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Working words and the store hold no reset value.
	always_ff @(posedge clk) begin
		if (state_q == KS_LOAD) begin
			k_q <= key_q ^ FK;
		end else if (state_q == KS_RUN) begin
			k_q         <= {nk, k_q[3], k_q[2], k_q[1]};
			rk_q[cnt_q] <= nk;
		end
	end

	assign keys_ready = (state_q == KS_READY);
	assign rk         = rk_q;

	a_run_ends_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == KS_RUN) && (cnt_q == LAST_RND) && !cfg_we |=> keys_ready)
		else $error("key expansion did not finish after the last round");

	a_write_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !keys_ready)
		else $error("round keys marked ready right after a key write");

endmodule

// ===== hw/rtl/sm4_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// SM4 block cipher unit
// Fully unrolled 32-round SM4 encrypt/decrypt pipeline with on-chip key
// expansion.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    s_tdata block words, s_tuser operation
// m_*       out        m_tvalid/m_tready    m_tdata result words
// cfg_*     in         cfg_we               cfg_idx key word index, cfg_wdata value
//
// Each block passes one register stage per round, and a new block may enter
// every cycle while the pipeline is not stalled; the last round register is the output.
// After reset or any key write the key sequencer runs one load step and 32 key
// rounds before s_tready can rise.
// The whole pipeline holds when a result is presented and m_tready is low; a
// stall drops and repeats no transaction.
//
module sm4_block_cipher_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Slave side.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata from bit 0: block_in_0, block_in_1, block_in_2, block_in_3.
	input  logic [sm4_pkg::BLOCK_W-1:0]   s_tdata,
	// s_tuser: operation (0 decrypt, 1 encrypt).
	input  logic                          s_tuser,
	// Master side.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata from bit 0: block_out_0, block_out_1, block_out_2, block_out_3.
	output logic [sm4_pkg::BLOCK_W-1:0]   m_tdata,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sm4_pkg::WORD_W-1:0]    cfg_wdata
);
	import sm4_pkg::*;

	logic                  keys_ready;
	rk_vec_t               rk;
	logic                  adv;
	logic [NUM_ROUNDS:0]   vld;
	stage_t                pipe [NUM_ROUNDS+1];
	stage_t                last_blk;

	sm4_key_exp u_key_exp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.keys_ready (keys_ready),
		.rk         (rk)
	);

	// The pipeline moves whenever the output register is free or being drained.
	assign adv      = !vld[NUM_ROUNDS] || m_tready;
	assign s_tready = keys_ready && adv;

	// Stage 0 is the incoming transaction itself.
	assign vld[0]     = s_tvalid && s_tready;
	assign pipe[0].op = s_tuser;
	assign pipe[0].x  = s_tdata;

	// Round r uses key r when encrypting and key 31-r when decrypting; each stage
	// reads two fixed entries of the store and picks by its own operation flag.
	for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
		logic [WORD_W-1:0] rk_sel;

		assign rk_sel = (pipe[r].op == OP_ENCRYPT) ? rk[r] : rk[NUM_ROUNDS-1-r];

		sm4_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (vld[r]),
			.in_blk    (pipe[r]),
			.rk        (rk_sel),
			.out_valid (vld[r+1]),
			.out_blk   (pipe[r+1])
		);
	end

	// The final word reversal is pure wiring.
	assign last_blk = pipe[NUM_ROUNDS];
	assign m_tvalid = vld[NUM_ROUNDS];
	assign m_tdata  = {last_blk.x[0], last_blk.x[1], last_blk.x[2], last_blk.x[3]};

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld[1])
		else $error("accepted block did not reach the first round register");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld[NUM_ROUNDS:1]))
		else $error("pipeline valid bits moved during a stall");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !vld[NUM_ROUNDS-1] |=> !m_tvalid)
		else $error("result repeated after it was taken");

endmodule

// ===== verif/sm4_checker.sv =====
// ----------------------------------------------------------------------------
// SM4 result checker
// Watches the key port and both streams of the SM4 unit, keeps its own key
// schedule, predicts each result block and compares it word by word.
// ----------------------------------------------------------------------------
module sm4_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// s_tdata from bit 0: block_in_0, block_in_1, block_in_2, block_in_3.
	input  logic [sm4_pkg::BLOCK_W-1:0]   s_tdata,
	// s_tuser: operation.
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata from bit 0: block_out_0, block_out_1, block_out_2, block_out_3.
	input  logic [sm4_pkg::BLOCK_W-1:0]   m_tdata,
	input  logic                          cfg_we,
	input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sm4_pkg::WORD_W-1:0]    cfg_wdata,
	output int                            errors,
	output int                            pending
);
	import sm4_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] block_t;

	localparam logic [7:0] SUBST [256] = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

	localparam logic [WORD_W-1:0] SYS_PARAM [NUM_WORDS] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	logic [WORD_W-1:0] key_reg [NUM_WORDS];
	logic [WORD_W-1:0] round_keys [NUM_ROUNDS];
	bit                schedule_valid;
	block_t            expected_blocks [$];
	block_t            want;
	bit [NUM_WORDS-1:0] bad_words;
	int                results_seen;

	function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] sub_bytes(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] r;
		for (int b = 0; b < 4; b++)
			r[8*b +: 8] = SUBST[v[8*b +: 8]];
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] s;
		s = sub_bytes(v);
		return s ^ rot_left(s, 2) ^ rot_left(s, 10) ^ rot_left(s, 18) ^ rot_left(s, 24);
	endfunction

	function automatic logic [WORD_W-1:0] sched_mix(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] s;
		s = sub_bytes(v);
		return s ^ rot_left(s, 13) ^ rot_left(s, 23);
	endfunction

	// Byte j of chain word i, most significant byte first, is (4i+j)*7 mod 256.
	function automatic logic [WORD_W-1:0] chain_word(input int i);
		logic [WORD_W-1:0] c;
		c = '0;
		for (int j = 0; j < 4; j++)
			c = {c[WORD_W-9:0], 8'(((4 * i + j) * 7) & 255)};
		return c;
	endfunction

	function automatic void expand_round_keys();
		logic [WORD_W-1:0] k [NUM_WORDS];
		logic [WORD_W-1:0] nk;
		for (int i = 0; i < NUM_WORDS; i++)
			k[i] = key_reg[i] ^ SYS_PARAM[i];
		for (int r = 0; r < NUM_ROUNDS; r++) begin
			nk = k[0] ^ sched_mix(k[1] ^ k[2] ^ k[3] ^ chain_word(r));
			round_keys[r] = nk;
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = nk;
		end
		schedule_valid = 1'b1;
	endfunction

	function automatic block_t sm4_crypt_block(input logic op, input block_t din);
		logic [WORD_W-1:0] x [NUM_WORDS];
		logic [WORD_W-1:0] rk;
		logic [WORD_W-1:0] nx;
		block_t            dout;
		for (int i = 0; i < NUM_WORDS; i++)
			x[i] = din[i];
		for (int r = 0; r < NUM_ROUNDS; r++) begin
			rk = (op == OP_ENCRYPT) ? round_keys[r] : round_keys[NUM_ROUNDS-1-r];
			nx = x[0] ^ round_mix(x[1] ^ x[2] ^ x[3] ^ rk);
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = nx;
		end
		for (int i = 0; i < NUM_WORDS; i++)
			dout[i] = x[NUM_WORDS-1-i];
		return dout;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_reg = '{default: '0};
			schedule_valid = 1'b0;
			expected_blocks.delete();
			pending = 0;
			errors = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_KEY_0: key_reg[0] = cfg_wdata;
					REG_KEY_1: key_reg[1] = cfg_wdata;
					REG_KEY_2: key_reg[2] = cfg_wdata;
					REG_KEY_3: key_reg[3] = cfg_wdata;
					default: ;
				endcase
				schedule_valid = 1'b0;
			end
			if (s_tvalid && s_tready) begin
				if (!schedule_valid)
					expand_round_keys();
				expected_blocks.push_back(sm4_crypt_block(s_tuser, s_tdata));
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_blocks.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("Result %0d arrived with no block outstanding: %h",
							results_seen, m_tdata);
				end else begin
					want = expected_blocks.pop_front();
					for (int w = 0; w < NUM_WORDS; w++)
						bad_words[w] = (m_tdata[w*WORD_W +: WORD_W] !== want[w]);
					if (bad_words != '0) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("Result %0d wrong in words %b: expected %h, got %h",
								results_seen, bad_words, want, m_tdata);
					end
				end
			end
			pending = expected_blocks.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// SM4 block cipher unit testbench
// Drives key writes and block transactions into the unit under several
// handshake pressure profiles; the checker predicts every result block.
// ----------------------------------------------------------------------------
module testbench;

	import sm4_pkg::*;

	localparam int RESET_CYCLES    = 10;
	// A quiet stretch longer than this means the unit is hung. The longest
	// legal one is the receiver hold-off plus a drained pipeline.
	localparam int IDLE_LIMIT      = 2000;
	localparam int HOLD_OFF_CYCLES = 200;
	// The pipeline is 32 rounds deep; this covers any straggler after the end.
	localparam int DRAIN_TAIL      = 40;
	localparam int NUM_PHASES      = 4;
	localparam int ITEMS_PER_PHASE = 180;

	// Key registers in index order, so loops can address them by position.
	localparam logic [CFG_IDX_W-1:0] KEY_REGS [NUM_WORDS] = '{
		REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [BLOCK_W-1:0]   s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [BLOCK_W-1:0]   m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [WORD_W-1:0]    cfg_wdata;

	int errors;
	int pending;
	int src_idle_pct;
	int sink_stall_pct;
	bit hold_off_req;
	int quiet_cycles;

	sm4_block_cipher_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	sm4_checker check_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver. On a hold-off request it keeps m_tready low for a long,
	// self-counted stretch so the pipeline fills and s_tready drops; otherwise
	// it stalls at random at the rate of the current phase.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Watchdog: any cycle that moves a transaction on either stream resets
	// the count. If the count ever reaches the limit the unit is hung.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [BLOCK_W-1:0] pack_words(input logic [WORD_W-1:0] w0,
		input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
		input logic [WORD_W-1:0] w3);
		return {w3, w2, w1, w0};
	endfunction

	// Random word that lands on the all-zero and all-one extremes now and then.
	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [BLOCK_W-1:0] rand_block();
		return pack_words(rand_word(), rand_word(), rand_word(), rand_word());
	endfunction

	function automatic logic rand_op();
		return $urandom_range(1) ? OP_ENCRYPT : OP_DECRYPT;
	endfunction

	// Offers one block and returns at the rising edge where it was taken.
	// The sender idles a random number of cycles first, at the phase rate;
	// back-to-back calls keep s_tvalid high with fresh data.
	task automatic push_block(input logic op, input logic [BLOCK_W-1:0] data);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops offering and waits until every predicted result has come back.
	// The checker updates its count at the rising edge, so it is read only
	// after the falling edge that follows the last transaction.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
	endtask

	// Writes the key words selected by the mask, one per cycle. Only called
	// with the unit idle, after a drain.
	task automatic write_key(input logic [NUM_WORDS-1:0] mask,
		input logic [NUM_WORDS-1:0][WORD_W-1:0] key);
		for (int i = 0; i < NUM_WORDS; i++) begin
			if (mask[i]) begin
				@(negedge clk);
				cfg_we    <= 1'b1;
				cfg_idx   <= KEY_REGS[i];
				cfg_wdata <= key[i];
			end
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = OP_DECRYPT;
		cfg_we         = 1'b0;
		cfg_idx        = REG_KEY_0;
		cfg_wdata      = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_off_req   = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. First the reset key, which was never written: the
		// unit must expand it on its own before taking the first block.
		push_block(OP_ENCRYPT, '0);
		push_block(OP_DECRYPT, '0);
		push_block(OP_ENCRYPT, '1);

		// The published key and plaintext, plus its ciphertext going back
		// through decryption, then extreme and alternating bit patterns.
		drain();
		write_key('1, pack_words(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210));
		push_block(OP_ENCRYPT,
			pack_words(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210));
		push_block(OP_DECRYPT,
			pack_words(32'h681edf34, 32'hd206965e, 32'h86b3e94f, 32'h536e4246));
		push_block(OP_ENCRYPT, '0);
		push_block(OP_DECRYPT, '0);
		push_block(OP_ENCRYPT, '1);
		push_block(OP_DECRYPT, '1);
		push_block(OP_ENCRYPT,
			pack_words(32'h80000000, 32'h00000001, 32'haaaaaaaa, 32'h55555555));
		push_block(OP_DECRYPT,
			pack_words(32'h80000000, 32'h00000001, 32'haaaaaaaa, 32'h55555555));
		push_block(OP_ENCRYPT,
			pack_words(32'hffffffff, 32'h00000000, 32'hffffffff, 32'h00000000));
		push_block(OP_DECRYPT,
			pack_words(32'h00000000, 32'hffffffff, 32'h00000000, 32'hffffffff));

		// Changing a single key word must still force a fresh expansion.
		drain();
		write_key(4'b0100, {4{32'h5a5a5a5a}});
		push_block(OP_ENCRYPT, '0);
		push_block(OP_DECRYPT, '1);

		// Key extremes: all ones, then all zeros written explicitly.
		drain();
		write_key('1, '1);
		push_block(OP_ENCRYPT, '0);
		push_block(OP_DECRYPT, '1);
		push_block(OP_ENCRYPT, '1);
		drain();
		write_key('1, '0);
		push_block(OP_ENCRYPT, '1);
		push_block(OP_DECRYPT, '0);

		// Random part. Each phase has its own idling profile and a fresh key;
		// halfway through, the sender pauses until all results are back and
		// one key word is rewritten.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
				default: begin src_idle_pct = 31; sink_stall_pct = 31; end
			endcase
			write_key('1, pack_words(rand_word(), rand_word(), rand_word(), rand_word()));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2) begin
					drain();
					write_key(4'b0001 << $urandom_range(NUM_WORDS - 1),
						pack_words(rand_word(), rand_word(), rand_word(), rand_word()));
				end
				// Long receiver hold-off while the sender keeps offering,
				// so the pipeline fills and back-pressure reaches the input.
				if (ph == 0 && n == 40)
					hold_off_req = 1'b1;
				push_block(rand_op(), rand_block());
			end
		end

		drain();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
